// ===== hw/rtl/stc_pkg.sv =====
// shared types and constants for the system timer with compare channels
package stc_pkg;

    localparam int DATA_W       = 32;
    localparam int COUNT_W      = 64;
    localparam int IRQ_W        = 4;
    localparam int MAX_CHANNELS = 8;
    localparam int DEF_CHANNELS = 4;

    // command codes
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // register indexes
    localparam logic [2:0] REG_STATUS   = 3'd0;
    localparam logic [2:0] REG_COUNT_LO = 3'd1;
    localparam logic [2:0] REG_COUNT_HI = 3'd2;
    localparam logic [2:0] REG_CMP_BASE = 3'd3;

    typedef struct packed {
        logic [1:0]        command;
        logic [2:0]        reg_index;
        logic [DATA_W-1:0] write_value;
    } req_t;

endpackage

// ===== hw/rtl/stc_in_reg.sv =====
// input register stage holding one request beat
module stc_in_reg (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  stc_pkg::req_t s_req,
    output logic         req_valid,
    output stc_pkg::req_t req,
    input  logic         req_take
);

    logic          vld_reg;
    stc_pkg::req_t req_reg;

    // free when empty or when the held beat moves on this cycle
    assign s_ready   = !vld_reg || req_take;
    assign req_valid = vld_reg;
    assign req       = req_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            vld_reg <= 1'b1;
        end else if (req_take) begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req;
        end
    end

endmodule

// ===== hw/rtl/stc_timer_core.sv =====
// counter, compare registers, match flags and result register
module stc_timer_core #(
    parameter int CHANNELS = stc_pkg::DEF_CHANNELS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       req_valid,
    input  stc_pkg::req_t              req,
    output logic                       req_take,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [stc_pkg::DATA_W-1:0] m_read_value,
    output logic [stc_pkg::IRQ_W-1:0]  m_irq_lines
);

    logic [stc_pkg::COUNT_W-1:0] count_reg, count_next, count_inc;
    logic [CHANNELS-1:0]         flags_reg, flags_next;
    logic [stc_pkg::DATA_W-1:0]  cmp_reg  [CHANNELS];
    logic [stc_pkg::DATA_W-1:0]  cmp_next [CHANNELS];
    logic [stc_pkg::DATA_W-1:0]  rd_next;
    logic [stc_pkg::MAX_CHANNELS-1:0] flags_ext;
    logic [2:0]                  rel;
    logic                        cmp_sel;
    logic                        valid_reg;
    logic [stc_pkg::DATA_W-1:0]  rd_reg;
    logic [stc_pkg::IRQ_W-1:0]   irq_reg;

    assign req_take     = req_valid && (!valid_reg || m_ready);
    assign m_valid      = valid_reg;
    assign m_read_value = rd_reg;
    assign m_irq_lines  = irq_reg;

    assign count_inc = count_reg + stc_pkg::COUNT_W'(1);
    assign rel       = req.reg_index - stc_pkg::REG_CMP_BASE;
    assign cmp_sel   = (req.reg_index >= stc_pkg::REG_CMP_BASE)
                       && ({1'b0, rel} < 4'(CHANNELS));

    always_comb begin
        count_next = count_reg;
        flags_next = flags_reg;
        cmp_next   = cmp_reg;
        rd_next    = '0;
        case (req.command)
            stc_pkg::CMD_TICK: begin
                count_next = count_inc;
                for (int n = 0; n < CHANNELS; n++) begin
                    if (cmp_reg[n] == count_inc[stc_pkg::DATA_W-1:0]) begin
                        flags_next[n] = 1'b1;
                    end
                end
            end
            stc_pkg::CMD_READ: begin
                case (req.reg_index)
                    stc_pkg::REG_STATUS:   rd_next = stc_pkg::DATA_W'(flags_reg);
                    stc_pkg::REG_COUNT_LO: rd_next = count_reg[stc_pkg::DATA_W-1:0];
                    stc_pkg::REG_COUNT_HI:
                        rd_next = count_reg[stc_pkg::COUNT_W-1:stc_pkg::DATA_W];
                    default: begin
                        for (int n = 0; n < CHANNELS; n++) begin
                            if (cmp_sel && rel == 3'(n)) begin
                                rd_next = cmp_reg[n];
                            end
                        end
                    end
                endcase
            end
            stc_pkg::CMD_WRITE: begin
                // counter words are read-only
                if (req.reg_index == stc_pkg::REG_STATUS) begin
                    flags_next = flags_reg & ~req.write_value[CHANNELS-1:0];
                end else begin
                    for (int n = 0; n < CHANNELS; n++) begin
                        if (cmp_sel && rel == 3'(n)) begin
                            cmp_next[n] = req.write_value;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    assign flags_ext = stc_pkg::MAX_CHANNELS'(flags_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            flags_reg <= '0;
            valid_reg <= 1'b0;
            for (int n = 0; n < CHANNELS; n++) begin
                cmp_reg[n] <= '0;
            end
        end else begin
            if (req_take) begin
                count_reg <= count_next;
                flags_reg <= flags_next;
                cmp_reg   <= cmp_next;
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req_take) begin
            rd_reg  <= rd_next;
            irq_reg <= flags_ext[stc_pkg::IRQ_W-1:0];
        end
    end

`ifndef SYNTH
    // a tick advances the counter by exactly one
    assert property (@(posedge aclk) disable iff (!aresetn)
        req_take && req.command == stc_pkg::CMD_TICK
        |=> count_reg == $past(count_reg) + stc_pkg::COUNT_W'(1))
        else $error("counter did not advance on tick");

    // nothing but a tick moves the counter
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(req_take && req.command == stc_pkg::CMD_TICK) |=> $stable(count_reg))
        else $error("counter moved without a tick");

    // only a tick may raise a match flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(req_take && req.command == stc_pkg::CMD_TICK)
        |=> (flags_reg & ~$past(flags_reg)) == '0)
        else $error("match flag set without a tick");

    // a pending result shows the live match flags
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |->
        irq_reg == stc_pkg::IRQ_W'(stc_pkg::MAX_CHANNELS'(flags_reg)))
        else $error("irq lines out of step with match flags");
`endif

endmodule

// ===== hw/rtl/system_timer_compare_channels.sv =====
// top level of the system timer with compare-match channels
//
//   channel  ports                                    direction  width
//   s_       s_valid s_ready s_command s_reg_index    in         2+3+32
//            s_write_value
//   m_       m_valid m_ready m_read_value m_irq_lines out        32+4
//
// one beat in, one beat out; a request waits in the input register until the core
// takes it, and its result is registered in the output register as it is taken
// results flow at one beat per cycle while m_ready stays high
// the 64-bit increment and the per-channel compare set the cycle time
// aresetn clears the counter, compare registers, match flags and both valids
// while m_ready is low the result holds and one more request may wait in the
// input register, after which s_ready drops
module system_timer_compare_channels #(
    parameter int CHANNELS = stc_pkg::DEF_CHANNELS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // request channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_command,
    input  logic [2:0]                 s_reg_index,
    input  logic [stc_pkg::DATA_W-1:0] s_write_value,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [stc_pkg::DATA_W-1:0] m_read_value,
    output logic [stc_pkg::IRQ_W-1:0]  m_irq_lines
);

    stc_pkg::req_t s_req;
    stc_pkg::req_t req;
    logic          req_valid;
    logic          req_take;

    // pack the incoming beat
    assign s_req.command     = s_command;
    assign s_req.reg_index   = s_reg_index;
    assign s_req.write_value = s_write_value;

    // request register, refilled in the same cycle it drains
    stc_in_reg u_in_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .req_valid (req_valid),
        .req       (req),
        .req_take  (req_take)
    );

    // timer state plus the result register
    stc_timer_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req_valid    (req_valid),
        .req          (req),
        .req_take     (req_take),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_irq_lines  (m_irq_lines)
    );

endmodule
